### rtl/integer_to_radix_ascii_top_macros.svh
// assertion macros shared by the integer to radix ascii design
`ifndef INTEGER_TO_RADIX_ASCII_TOP_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ITOA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa assertion failed");
// next-cycle implication
`define ITOA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa assertion failed");
`else
`define ITOA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ITOA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/itoa_pkg.sv
// shared widths, ascii codes and digit encoding for the radix converter
package itoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int BASE_WIDTH  = 6;
  localparam int CHAR_WIDTH  = 7;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_WIDTH   = $clog2(VALUE_WIDTH);

  localparam logic [BASE_WIDTH-1:0] MIN_BASE     = BASE_WIDTH'(2);
  localparam logic [BASE_WIDTH-1:0] MAX_BASE     = BASE_WIDTH'(36);
  localparam logic [BASE_WIDTH-1:0] DECIMAL_BASE = BASE_WIDTH'(10);

  localparam logic [CHAR_WIDTH-1:0] ASCII_DIGIT_OFFSET  = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0] ASCII_LETTER_OFFSET = CHAR_WIDTH'(55);
  localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS         = CHAR_WIDTH'(45);
  localparam logic [CHAR_WIDTH-1:0] ASCII_NUL           = CHAR_WIDTH'(0);

  // digit value 0..35 to '0'..'9', 'A'..'Z'
  function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [BASE_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] dx;
    dx = {1'b0, d};
    if (d < DECIMAL_BASE) begin
      return ASCII_DIGIT_OFFSET + dx;
    end
    return ASCII_LETTER_OFFSET + dx;
  endfunction

endpackage

### rtl/itoa_if.sv
// valid/ready channels for the input value and the output characters
interface itoa_in_if
  import itoa_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic        [BASE_WIDTH-1:0]  base;

  modport source (output valid, value, base, input ready);
  modport sink   (input valid, value, base, output ready);
endinterface

interface itoa_out_if
  import itoa_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CHAR_WIDTH-1:0] ascii_char;
  logic                  last;
  logic                  bad_base;

  modport source (output valid, ascii_char, last, bad_base, input ready);
  modport sink   (input valid, ascii_char, last, bad_base, output ready);
endinterface

### rtl/itoa_div.sv
// restoring divider, one quotient bit per cycle, narrow divisor
module itoa_div
  import itoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [BASE_WIDTH-1:0]  divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [BASE_WIDTH-1:0]  remainder
);

  logic [VALUE_WIDTH-1:0] quo;
  logic [BASE_WIDTH-1:0]  rem;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   busy;

  logic [BASE_WIDTH:0]    trial;
  logic [BASE_WIDTH:0]    diff;
  logic                   fits;
  logic [BASE_WIDTH-1:0]  rem_next;

  // remainder stays below divisor, so trial fits one extra bit
  always_comb begin
    trial    = {rem, quo[VALUE_WIDTH-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? diff[BASE_WIDTH-1:0] : trial[BASE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        quo  <= dividend;
        rem  <= '0;
        cnt  <= CNT_WIDTH'(VALUE_WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[VALUE_WIDTH-2:0], fits};
        rem <= rem_next;
        cnt <= cnt - CNT_WIDTH'(1);
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### rtl/integer_to_radix_ascii_top.sv
// Integer to radix ASCII converter: takes one signed 32-bit value and a base from 2 to 36
// on the number channel and sends its digits, most significant first, as ASCII words on the
// text channel ('0'..'9', 'A'..'Z'), with last set on the final word. Zero gives one '0'.
// In base 10 a negative value is sent as '-' and then its magnitude; in other bases the
// value is read as an unsigned two's complement pattern. A base outside 2..36 gives a single
// word with bad_base set, ascii_char 0 and last set. One value is handled at a time: number
// is ready only while the block is idle. Every digit comes from one pass of a shared
// bit-serial divider; once all digits are found, the words are sent one by one from the
// output register, which holds a word while text is not ready. The final word may wait in
// the output register while the next value is taken in.
module integer_to_radix_ascii_top
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  itoa_in_if.sink     number,
  itoa_out_if.source  text
);

`include "integer_to_radix_ascii_top_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                 state;

  // working value and conversion flags
  logic [VALUE_WIDTH-1:0] work;
  logic [BASE_WIDTH-1:0]  base_r;
  logic                   neg;
  logic                   bad;

  // digit stack, least significant digit written first
  logic [BASE_WIDTH-1:0]  digits [VALUE_WIDTH];
  logic [CNT_WIDTH-1:0]   nd;
  logic [CNT_WIDTH-1:0]   nd_m1;

  // divider handshake
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [BASE_WIDTH-1:0]  div_rem;

  // output register
  logic                   out_valid;
  logic [CHAR_WIDTH-1:0]  out_char;
  logic                   out_last;
  logic                   out_bad;
  logic                   out_free;

  logic                   in_neg;
  logic                   in_bad;

  itoa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (work),
    .divisor   (base_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign number.ready = (state == S_IDLE);

  // output word can be loaded when empty or being taken this cycle
  assign out_free = !out_valid || text.ready;
  assign nd_m1    = nd - CNT_WIDTH'(1);

  assign in_bad = (number.base < MIN_BASE) || (number.base > MAX_BASE);
  assign in_neg = (number.base == DECIMAL_BASE) && number.value[VALUE_WIDTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      nd        <= '0;
      neg       <= 1'b0;
      bad       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && text.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (number.valid) begin
            base_r <= number.base;
            nd     <= '0;
            neg    <= 1'b0;
            bad    <= 1'b0;
            if (in_bad) begin
              bad   <= 1'b1;
              state <= S_EMIT;
            end else if (number.value == '0) begin
              // zero prints as a single '0'
              digits[0] <= '0;
              nd        <= CNT_WIDTH'(1);
              state     <= S_EMIT;
            end else begin
              // magnitude of the most negative value is still right as unsigned
              neg       <= in_neg;
              work      <= in_neg ? (~number.value + VALUE_WIDTH'(1)) : number.value;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            digits[nd[IDX_WIDTH-1:0]] <= div_rem;
            nd <= nd + CNT_WIDTH'(1);
            if (div_quo == '0) begin
              state <= S_EMIT;
            end else begin
              work      <= div_quo;
              div_start <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (bad) begin
              out_char <= ASCII_NUL;
              out_last <= 1'b1;
              out_bad  <= 1'b1;
              state    <= S_IDLE;
            end else if (neg) begin
              // sign goes out ahead of the digits
              out_char <= ASCII_MINUS;
              out_last <= 1'b0;
              out_bad  <= 1'b0;
              neg      <= 1'b0;
            end else begin
              out_char <= digit_to_ascii(digits[nd_m1[IDX_WIDTH-1:0]]);
              out_last <= (nd == CNT_WIDTH'(1));
              out_bad  <= 1'b0;
              nd       <= nd_m1;
              if (nd == CNT_WIDTH'(1)) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign text.valid      = out_valid;
  assign text.ascii_char = out_char;
  assign text.last       = out_last;
  assign text.bad_base   = out_bad;

  `ITOA_ASSERT_NXT(a_busy_after_accept, clk, rst, number.valid && number.ready, !number.ready)
  `ITOA_ASSERT_IMP(a_bad_word, clk, rst, text.valid && text.bad_base, (text.ascii_char == ASCII_NUL) && text.last)
  `ITOA_ASSERT_IMP(a_digit_bound, clk, rst, 1'b1, nd <= CNT_WIDTH'(VALUE_WIDTH))
  `ITOA_ASSERT_IMP(a_done_in_div, clk, rst, div_done || div_start, state == S_DIV)

endmodule
